>>> design/rne_pkg.sv
package rne_pkg;

  localparam int unsigned VALUE_W   = 12;
  localparam int unsigned SYMBOL_W  = 8;
  localparam int unsigned NUM_STEPS = 13;
  localparam int unsigned STEP_W    = 4;

  localparam logic [SYMBOL_W-1:0] NO_SYMBOL = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SECOND
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic emit_first;
    logic emit_second;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic value_zero;
    logic two_char;
    logic rem_zero;
    logic rest_zero;
  } sts_t;

  // weight of each step, largest first
  function automatic logic [VALUE_W-1:0] step_weight(input logic [STEP_W-1:0] idx);
    logic [VALUE_W-1:0] w;
    unique case (idx)
      4'd0:    w = 12'd1000;
      4'd1:    w = 12'd900;
      4'd2:    w = 12'd500;
      4'd3:    w = 12'd400;
      4'd4:    w = 12'd100;
      4'd5:    w = 12'd90;
      4'd6:    w = 12'd50;
      4'd7:    w = 12'd40;
      4'd8:    w = 12'd10;
      4'd9:    w = 12'd9;
      4'd10:   w = 12'd5;
      4'd11:   w = 12'd4;
      4'd12:   w = 12'd1;
      default: w = 12'd0;
    endcase
    return w;
  endfunction

  // leading character of each step
  function automatic logic [SYMBOL_W-1:0] step_first(input logic [STEP_W-1:0] idx);
    logic [SYMBOL_W-1:0] c;
    unique case (idx)
      4'd0:    c = "M";
      4'd1:    c = "C";
      4'd2:    c = "D";
      4'd3:    c = "C";
      4'd4:    c = "C";
      4'd5:    c = "X";
      4'd6:    c = "L";
      4'd7:    c = "X";
      4'd8:    c = "X";
      4'd9:    c = "I";
      4'd10:   c = "V";
      4'd11:   c = "I";
      4'd12:   c = "I";
      default: c = NO_SYMBOL;
    endcase
    return c;
  endfunction

  // trailing character of the subtractive steps, none otherwise
  function automatic logic [SYMBOL_W-1:0] step_second(input logic [STEP_W-1:0] idx);
    logic [SYMBOL_W-1:0] c;
    unique case (idx)
      4'd1:    c = "M";
      4'd3:    c = "D";
      4'd5:    c = "C";
      4'd7:    c = "L";
      4'd9:    c = "X";
      4'd11:   c = "V";
      default: c = NO_SYMBOL;
    endcase
    return c;
  endfunction

endpackage

>>> design/roman_numeral_encoder_unit.sv
// channel  | ports                 | transaction taken when
// ---------+-----------------------+------------------------------
// input    | start, busy, value    | start high while busy low
// result   | strobe, symbol, last  | every cycle strobe is high
//
// a number taken is loaded into the remainder register, and its characters
// then show from the output register, one per cycle; busy stays high while
// the characters of a number are produced, set by the single step-select and
// subtract unit that handles one character per cycle, and the next number can
// be taken at the edge that ends the last character. zero is taken and gives
// no transaction. rst is synchronous and returns the controller to idle,
// strobe low. the receiver cannot stall: each character is shown for
// exactly one cycle.
module roman_numeral_encoder_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [rne_pkg::VALUE_W-1:0]  value,
  output logic                         strobe,
  output logic [rne_pkg::SYMBOL_W-1:0] symbol,
  output logic                         last
);

  rne_pkg::cmd_t cmd;
  rne_pkg::sts_t sts;

  // sequencing
  rne_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // remainder, step selection and output register
  rne_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .value  (value),
    .cmd    (cmd),
    .sts    (sts),
    .symbol (symbol),
    .last   (last),
    .strobe (strobe)
  );

endmodule

>>> design/rne_datapath.sv
module rne_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [rne_pkg::VALUE_W-1:0]      value,
  input  rne_pkg::cmd_t                    cmd,
  output rne_pkg::sts_t                    sts,
  output logic [rne_pkg::SYMBOL_W-1:0]     symbol,
  output logic                             last,
  output logic                             strobe
);

  logic [rne_pkg::VALUE_W-1:0]  rest;
  logic [rne_pkg::SYMBOL_W-1:0] pending;
  logic [rne_pkg::STEP_W-1:0]   sel;
  logic [rne_pkg::VALUE_W-1:0]  rem;
  logic                         two_char;

  // largest step that still fits the remainder
  always_comb begin
    sel = '0;
    for (int s = rne_pkg::NUM_STEPS - 1; s >= 0; s--) begin
      if (rest >= rne_pkg::step_weight(rne_pkg::STEP_W'(s))) begin
        sel = rne_pkg::STEP_W'(s);
      end
    end
  end

  assign rem      = rest - rne_pkg::step_weight(sel);
  assign two_char = (rne_pkg::step_second(sel) != rne_pkg::NO_SYMBOL);

  // status to the controller
  always_comb begin
    sts.value_zero = (value == '0);
    sts.two_char   = two_char;
    sts.rem_zero   = (rem == '0);
    sts.rest_zero  = (rest == '0);
  end

  // remainder and pending second character
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest <= value;
    end else if (cmd.emit_first) begin
      rest    <= rem;
      pending <= rne_pkg::step_second(sel);
    end
  end

  // output register for one character
  always_ff @(posedge clk) begin
    if (cmd.emit_first) begin
      symbol <= rne_pkg::step_first(sel);
      last   <= !two_char && (rem == '0);
    end else if (cmd.emit_second) begin
      symbol <= pending;
      last   <= (rest == '0);
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_first | cmd.emit_second;
    end
  end

endmodule

>>> design/rne_controller.sv
module rne_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  rne_pkg::sts_t sts,
  output rne_pkg::cmd_t cmd,
  output logic          busy
);

  rne_pkg::state_t state;
  rne_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rne_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next      = state;
    cmd.load        = 1'b0;
    cmd.emit_first  = 1'b0;
    cmd.emit_second = 1'b0;
    unique case (state)
      rne_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          // zero has the empty numeral
          if (!sts.value_zero) begin
            state_next = rne_pkg::ST_RUN;
          end
        end
      end
      rne_pkg::ST_RUN: begin
        cmd.emit_first = 1'b1;
        if (sts.two_char) begin
          state_next = rne_pkg::ST_SECOND;
        end else if (sts.rem_zero) begin
          state_next = rne_pkg::ST_IDLE;
        end
      end
      rne_pkg::ST_SECOND: begin
        cmd.emit_second = 1'b1;
        state_next = sts.rest_zero ? rne_pkg::ST_IDLE : rne_pkg::ST_RUN;
      end
      default: begin
        state_next = rne_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != rne_pkg::ST_IDLE);

endmodule

>>> bench/numeral_checker.sv
module numeral_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [rne_pkg::VALUE_W-1:0]  value,
  input  logic                         strobe,
  input  logic [rne_pkg::SYMBOL_W-1:0] symbol,
  input  logic                         last,
  output int unsigned                  mismatches,
  output int unsigned                  outstanding,
  output int unsigned                  chars_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_CAP = 30;

  // numeral letters
  localparam logic [rne_pkg::SYMBOL_W-1:0] SYM_I = "I";
  localparam logic [rne_pkg::SYMBOL_W-1:0] SYM_V = "V";
  localparam logic [rne_pkg::SYMBOL_W-1:0] SYM_X = "X";
  localparam logic [rne_pkg::SYMBOL_W-1:0] SYM_L = "L";
  localparam logic [rne_pkg::SYMBOL_W-1:0] SYM_C = "C";
  localparam logic [rne_pkg::SYMBOL_W-1:0] SYM_D = "D";
  localparam logic [rne_pkg::SYMBOL_W-1:0] SYM_M = "M";

  typedef struct packed {
    logic [rne_pkg::SYMBOL_W-1:0] symbol;
    logic                         last;
  } numeral_char_t;

  numeral_char_t awaited_chars[$];

  initial begin
    mismatches    = 0;
    outstanding   = 0;
    chars_checked = 0;
  end

  // one line per mismatch, quiet after the cap but still counted
  task automatic report_mismatch(input string what);
    if (mismatches < REPORT_CAP) begin
      $display("[%0t ns] mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic void add_char(input logic [rne_pkg::SYMBOL_W-1:0] letter);
    numeral_char_t c;
    c.symbol = letter;
    c.last   = 1'b0;
    awaited_chars.push_back(c);
  endfunction

  // one decimal digit from its unit, half and next-place letters
  function automatic void spell_digit(input int unsigned digit,
                                      input logic [rne_pkg::SYMBOL_W-1:0] unit_sym,
                                      input logic [rne_pkg::SYMBOL_W-1:0] half_sym,
                                      input logic [rne_pkg::SYMBOL_W-1:0] next_sym);
    int unsigned k;
    if (digit == 9) begin
      add_char(unit_sym);
      add_char(next_sym);
    end else if (digit >= 5) begin
      add_char(half_sym);
      for (k = 5; k < digit; k++) add_char(unit_sym);
    end else if (digit == 4) begin
      add_char(unit_sym);
      add_char(half_sym);
    end else begin
      for (k = 0; k < digit; k++) add_char(unit_sym);
    end
  endfunction

  // whole numeral for one number; values past 3999 just add more thousands
  function automatic void spell_number(input logic [rne_pkg::VALUE_W-1:0] number);
    int unsigned n;
    int unsigned size_before;
    int unsigned k;
    numeral_char_t tail;
    n = number;
    size_before = awaited_chars.size();
    for (k = 0; k < n / 1000; k++) add_char(SYM_M);
    spell_digit((n / 100) % 10, SYM_C, SYM_D, SYM_M);
    spell_digit((n / 10) % 10, SYM_X, SYM_L, SYM_C);
    spell_digit(n % 10, SYM_I, SYM_V, SYM_X);
    // zero spells nothing, so there is no last mark to set
    if (awaited_chars.size() > size_before) begin
      tail = awaited_chars.pop_back();
      tail.last = 1'b1;
      awaited_chars.push_back(tail);
    end
  endfunction

  // compare each result transaction, then log any new input transaction
  always @(posedge clk) begin
    numeral_char_t want;
    if (!rst) begin
      if (strobe !== 1'b0) begin
        if (awaited_chars.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h with none awaited", symbol));
        end else begin
          want = awaited_chars.pop_front();
          chars_checked++;
          if (symbol !== want.symbol) begin
            report_mismatch($sformatf("symbol 0x%02h, expected '%c'", symbol, want.symbol));
          end
          if (last !== want.last) begin
            report_mismatch($sformatf("last %b on '%c', expected %b",
                                      last, want.symbol, want.last));
          end
        end
      end
      if (start && !busy) spell_number(value);
    end
    outstanding = awaited_chars.size();
  end

endmodule

>>> bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_NUMBERS = 335;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned DRAIN_CYCLES   = 24;
  localparam int unsigned RESET_CYCLES   = 8;
  localparam int unsigned NUM_LANDMARKS  = 25;

  logic                         clk   = 1'b0;
  logic                         rst   = 1'b1;
  logic                         start = 1'b0;
  logic [rne_pkg::VALUE_W-1:0]  value = '0;
  logic                         busy;
  logic                         strobe;
  logic [rne_pkg::SYMBOL_W-1:0] symbol;
  logic                         last;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned chars_checked;
  int unsigned cycles       = 0;
  int unsigned numbers_sent = 0;
  logic        took         = 1'b0;
  bit          steady_feed  = 1'b0;

  // every subtractive form, each digit shape but 2, zero, the longest numeral and the top range
  int unsigned landmarks [NUM_LANDMARKS] = '{
    0, 1, 3, 4, 5, 8, 9, 10, 40, 50, 90, 100, 400, 444, 500,
    900, 999, 1000, 1994, 2730, 1365, 3888, 3999, 4000, 4095
  };

  always #5 clk = ~clk;

  roman_numeral_encoder_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .value  (value),
    .strobe (strobe),
    .symbol (symbol),
    .last   (last)
  );

  numeral_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .value         (value),
    .strobe        (strobe),
    .symbol        (symbol),
    .last          (last),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .chars_checked (chars_checked)
  );

  // handshake flag for the driver, plus the watchdog
  always @(posedge clk) begin
    took <= !rst && start && !busy;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d characters awaited",
               cycles, outstanding);
      $display("roman_numeral_encoder_unit verification failed");
      $finish;
    end
  end

  // present one number after a random gap, or none when feeding steadily, and hold it until taken
  task automatic send_number(input logic [rne_pkg::VALUE_W-1:0] number);
    int unsigned gap;
    gap = steady_feed ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      value <= rne_pkg::VALUE_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    value <= number;
    do @(negedge clk); while (!took);
    numbers_sent++;
  endtask

  // mostly the meant range, with zero, small numbers and the range past 3999 mixed in
  function automatic logic [rne_pkg::VALUE_W-1:0] pick_number();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return '0;
    if (roll < 14) return rne_pkg::VALUE_W'($urandom_range(4000, 4095));
    if (roll < 26) return rne_pkg::VALUE_W'($urandom_range(1, 49));
    return rne_pkg::VALUE_W'($urandom_range(1, 3999));
  endfunction

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (landmarks[i]) begin
      if ($urandom_range(0, 7) == 0) steady_feed = !steady_feed;
      send_number(rne_pkg::VALUE_W'(landmarks[i]));
    end
    for (int unsigned n = 0; n < RANDOM_NUMBERS; n++) begin
      if ($urandom_range(0, 15) == 0) steady_feed = !steady_feed;
      send_number(pick_number());
    end
    start <= 1'b0;

    // let the last numeral finish, then a little longer for stray characters
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d numbers converted (landmarks, zero, 4000..4095 and random values)",
             numbers_sent);
    $display("%0d numeral characters checked, %0d mismatches", chars_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("roman_numeral_encoder_unit verification clean");
    end else begin
      $display("roman_numeral_encoder_unit verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/rne_pkg.sv
design/rne_datapath.sv
design/rne_controller.sv
design/roman_numeral_encoder_unit.sv
bench/numeral_checker.sv
bench/testbench.sv
